[rtl/bnpc_pkg.sv]
// Package for the bus node poll controller: constants, mode and command codes,
// and the command and status structs exchanged between sequencer and datapath.
// No dependencies.
package bnpc_pkg;

	localparam int MAX_NODE_SLOTS = 32;
	localparam int NODE_W         = $clog2(MAX_NODE_SLOTS);
	localparam int CNT_W          = 6;
	localparam int ADDR_W         = 5;
	localparam int TIMER_W        = 16;
	localparam int MASK_W         = 8;
	localparam int RADIUS_W       = 2;
	localparam int CODE_W         = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	// Effective node count: limited by the table depth and by the 5-bit address.
	localparam int EFF_MAX = (MAX_NODE_SLOTS < 32) ? MAX_NODE_SLOTS : 32;

	localparam logic [CNT_W-1:0]    RST_NODE_COUNT = CNT_W'(25);
	localparam logic [RADIUS_W-1:0] RST_RADIUS     = RADIUS_W'(1);
	localparam logic [TIMER_W-1:0]  RST_TIMEOUT    = TIMER_W'(10);
	localparam logic [MASK_W-1:0]   RST_OUT_MASK   = MASK_W'(128);
	localparam logic [MASK_W-1:0]   RST_IN_MASK    = MASK_W'(1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MASK   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_IN_MASK    = CFG_IDX_W'(4);

	// Command codes sent on the bus
	localparam logic [CODE_W-1:0] CODE_PROBE = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_QUERY = CODE_W'(1);
	localparam logic [CODE_W-1:0] CODE_SET   = CODE_W'(2);

	// Frame codes received from slaves
	localparam logic [CODE_W-1:0] FRAME_PRESENCE = CODE_W'(0);
	localparam logic [CODE_W-1:0] FRAME_REPORT   = CODE_W'(1);

	typedef enum logic [1:0] {
		MODE_DETECTING   = 2'd0,
		MODE_WAIT_PROBE  = 2'd1,
		MODE_QUERY       = 2'd2,
		MODE_WAIT_REPORT = 2'd3
	} mode_t;

	typedef struct packed {
		logic latch_tick;
		logic det_to_query;
		logic emit_probe;
		logic frame_apply;
		logic poll_inc;
		logic sweep_start;
		logic emit_query;
		logic sweep_step;
		logic sweep_done;
		logic timer_check;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  probe_lt_n;
		logic  poll_lt_n;
		logic  poll_avail;
		logic  sweep_lt_n;
		logic  out_free;
	} status_t;

endpackage

[rtl/bnpc_ctrl.sv]
// Sequencer for the bus node poll controller: walks one tick through mode
// action, availability scan, output sweep and timer check.
// Depends on bnpc_pkg.
module bnpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  bnpc_pkg::status_t sts,
	output bnpc_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACT,
		ST_SCAN,
		ST_SWEEP,
		ST_TIMER
	} state_t;

	state_t state_q, state_d;
	logic   rdy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_valid && rdy_q) begin
					cmd.latch_tick = 1'b1;
					state_d        = ST_ACT;
				end
			end
			ST_ACT: begin
				unique case (sts.mode)
					bnpc_pkg::MODE_DETECTING: begin
						if (!sts.probe_lt_n) begin
							cmd.det_to_query = 1'b1;
							state_d          = ST_TIMER;
						end else if (sts.out_free) begin
							cmd.emit_probe = 1'b1;
							state_d        = ST_TIMER;
						end
					end
					bnpc_pkg::MODE_QUERY: begin
						state_d = ST_SCAN;
					end
					default: begin
						cmd.frame_apply = 1'b1;
						state_d         = ST_TIMER;
					end
				endcase
			end
			ST_SCAN: begin
				// skip absent nodes one address per cycle
				if (!sts.poll_lt_n) begin
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end else if (!sts.poll_avail) begin
					cmd.poll_inc = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit_query = 1'b1;
					state_d        = ST_TIMER;
				end
			end
			ST_SWEEP: begin
				if (!sts.sweep_lt_n) begin
					cmd.sweep_done = 1'b1;
					state_d        = ST_TIMER;
				end else if (sts.out_free) begin
					cmd.sweep_step = 1'b1;
				end
			end
			ST_TIMER: begin
				cmd.timer_check = 1'b1;
				state_d         = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rdy_q   <= (state_d == ST_IDLE);
		end
	end

	assign tick_ready = rdy_q;

endmodule

[rtl/bnpc_dp.sv]
// Datapath for the bus node poll controller: configuration registers, node
// table, probe/poll/sweep indexes, reply timer, mode and the result register.
// Depends on bnpc_pkg.
module bnpc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bnpc_pkg::cmd_t                   cmd,
	output bnpc_pkg::status_t                sts,
	input  logic                             cfg_we,
	input  logic [bnpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bnpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             frame_valid,
	input  logic [bnpc_pkg::CODE_W-1:0]      frame_code,
	input  logic [bnpc_pkg::ADDR_W-1:0]      frame_address,
	input  logic [bnpc_pkg::MASK_W-1:0]      frame_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bnpc_pkg::ADDR_W-1:0]      send_address,
	output logic [bnpc_pkg::CODE_W-1:0]      send_code,
	output logic                             send_data,
	output logic                             last_command
);

	localparam int N = bnpc_pkg::MAX_NODE_SLOTS;
	localparam int CW = bnpc_pkg::CNT_W;

	// configuration
	logic [CW-1:0]                   node_count_q;
	logic [bnpc_pkg::RADIUS_W-1:0]   radius_q;
	logic [bnpc_pkg::TIMER_W-1:0]    timeout_q;
	logic [bnpc_pkg::MASK_W-1:0]     out_mask_q;
	logic [bnpc_pkg::MASK_W-1:0]     in_mask_q;

	// node table, one flop vector per attribute
	logic [N-1:0] avail_q, input_q, output_q;

	bnpc_pkg::mode_t                 mode_q;
	logic [CW-1:0]                   probe_q, poll_q, sweep_q;
	logic [bnpc_pkg::TIMER_W-1:0]    timer_q;

	// latched tick
	logic                            fv_q;
	logic [bnpc_pkg::CODE_W-1:0]     fcode_q;
	logic [bnpc_pkg::ADDR_W-1:0]     faddr_q;
	logic [bnpc_pkg::MASK_W-1:0]     fdata_q;

	logic                            ov_q;
	logic [bnpc_pkg::ADDR_W-1:0]     oaddr_q;
	logic [bnpc_pkg::CODE_W-1:0]     ocode_q;
	logic                            odata_q;
	logic                            olast_q;

	logic [CW-1:0]                   n_eff;
	logic                            out_free;
	logic                            addr_in_range;
	logic                            st_out_on, st_in_on;
	logic                            window_on;
	logic [CW:0]                     sw_ext, r_ext;
	logic [bnpc_pkg::NODE_W-1:0]     poll_idx, sweep_idx, faddr_idx;
	logic                            load_out;

	assign n_eff = (node_count_q > CW'(bnpc_pkg::EFF_MAX)) ? CW'(bnpc_pkg::EFF_MAX)
		: node_count_q;
	assign out_free      = !ov_q || out_ready;
	assign addr_in_range = {{(CW-bnpc_pkg::ADDR_W){1'b0}}, faddr_q} < n_eff;
	assign st_out_on     = (fdata_q & out_mask_q) == out_mask_q;
	assign st_in_on      = (fdata_q & in_mask_q) == in_mask_q;
	assign poll_idx      = poll_q[bnpc_pkg::NODE_W-1:0];
	assign sweep_idx     = sweep_q[bnpc_pkg::NODE_W-1:0];
	assign faddr_idx     = bnpc_pkg::NODE_W'(faddr_q);
	assign sw_ext        = {1'b0, sweep_q};
	assign r_ext         = (CW+1)'(radius_q);
	assign load_out      = cmd.emit_probe || cmd.emit_query || cmd.sweep_step;

	// OR of the input bits inside the neighbour window of the current sweep node
	always_comb begin
		logic [CW:0] jj;
		window_on = 1'b0;
		for (int j = 0; j < N; j++) begin
			jj = (CW+1)'(j);
			if (input_q[j] && (jj < {1'b0, n_eff}) && (jj + r_ext >= sw_ext)
					&& (jj <= sw_ext + r_ext))
				window_on = 1'b1;
		end
	end

	always_comb begin
		sts.mode       = mode_q;
		sts.probe_lt_n = probe_q < n_eff;
		sts.poll_lt_n  = poll_q < n_eff;
		sts.poll_avail = avail_q[poll_idx];
		sts.sweep_lt_n = sweep_q < n_eff;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= bnpc_pkg::RST_NODE_COUNT;
			radius_q     <= bnpc_pkg::RST_RADIUS;
			timeout_q    <= bnpc_pkg::RST_TIMEOUT;
			out_mask_q   <= bnpc_pkg::RST_OUT_MASK;
			in_mask_q    <= bnpc_pkg::RST_IN_MASK;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bnpc_pkg::CFG_NODE_COUNT: node_count_q <= cfg_wdata[CW-1:0];
				bnpc_pkg::CFG_RADIUS:     radius_q <= cfg_wdata[bnpc_pkg::RADIUS_W-1:0];
				bnpc_pkg::CFG_TIMEOUT:    timeout_q <= cfg_wdata;
				bnpc_pkg::CFG_OUT_MASK:   out_mask_q <= cfg_wdata[bnpc_pkg::MASK_W-1:0];
				bnpc_pkg::CFG_IN_MASK:    in_mask_q <= cfg_wdata[bnpc_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_tick) begin
			fv_q    <= frame_valid;
			fcode_q <= frame_code;
			faddr_q <= frame_address;
			fdata_q <= frame_data;
		end
		if (load_out) begin
			if (cmd.emit_probe) begin
				oaddr_q <= bnpc_pkg::ADDR_W'(probe_q);
				ocode_q <= bnpc_pkg::CODE_PROBE;
				odata_q <= 1'b0;
				olast_q <= 1'b1;
			end else if (cmd.emit_query) begin
				oaddr_q <= bnpc_pkg::ADDR_W'(poll_q);
				ocode_q <= bnpc_pkg::CODE_QUERY;
				odata_q <= 1'b0;
				olast_q <= 1'b1;
			end else begin
				oaddr_q <= bnpc_pkg::ADDR_W'(sweep_q);
				ocode_q <= bnpc_pkg::CODE_SET;
				odata_q <= window_on;
				olast_q <= (sweep_q + CW'(1)) == n_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q  <= '0;
			input_q  <= '0;
			output_q <= '0;
			mode_q   <= bnpc_pkg::MODE_DETECTING;
			probe_q  <= '0;
			poll_q   <= '0;
			sweep_q  <= '0;
			timer_q  <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (load_out)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;

			if (cmd.det_to_query)
				mode_q <= bnpc_pkg::MODE_QUERY;

			if (cmd.emit_probe) begin
				timer_q <= timeout_q;
				mode_q  <= bnpc_pkg::MODE_WAIT_PROBE;
				probe_q <= probe_q + CW'(1);
			end

			if (cmd.frame_apply && fv_q && addr_in_range) begin
				if (fcode_q == bnpc_pkg::FRAME_PRESENCE) begin
					avail_q[faddr_idx]  <= 1'b1;
					output_q[faddr_idx] <= st_out_on;
					input_q[faddr_idx]  <= st_in_on;
					mode_q <= (probe_q < n_eff) ? bnpc_pkg::MODE_DETECTING
						: bnpc_pkg::MODE_QUERY;
				end else if (fcode_q == bnpc_pkg::FRAME_REPORT) begin
					output_q[faddr_idx] <= st_out_on;
					input_q[faddr_idx]  <= st_in_on;
					mode_q <= bnpc_pkg::MODE_QUERY;
				end
			end

			if (cmd.poll_inc)
				poll_q <= poll_q + CW'(1);

			if (cmd.emit_query) begin
				timer_q <= timeout_q;
				mode_q  <= bnpc_pkg::MODE_WAIT_REPORT;
				poll_q  <= poll_q + CW'(1);
			end

			if (cmd.sweep_start) begin
				poll_q  <= '0;
				sweep_q <= '0;
			end

			if (cmd.sweep_step) begin
				output_q[sweep_idx] <= window_on;
				sweep_q <= sweep_q + CW'(1);
			end

			if (cmd.sweep_done)
				mode_q <= bnpc_pkg::MODE_WAIT_REPORT;

			if (cmd.timer_check) begin
				if (timer_q == '0) begin
					if (mode_q == bnpc_pkg::MODE_WAIT_PROBE)
						mode_q <= bnpc_pkg::MODE_DETECTING;
					else if (mode_q == bnpc_pkg::MODE_WAIT_REPORT)
						mode_q <= bnpc_pkg::MODE_QUERY;
				end else begin
					timer_q <= timer_q - bnpc_pkg::TIMER_W'(1);
				end
			end
		end
	end

	assign out_valid    = ov_q;
	assign send_address = oaddr_q;
	assign send_code    = ocode_q;
	assign send_data    = odata_q;
	assign last_command = olast_q;

endmodule

[rtl/bus_node_poll_controller_top.sv]
// Top level of the bus node poll controller: sequencer plus datapath.
// Depends on bnpc_pkg, bnpc_ctrl and bnpc_dp.
//
// Usage: each request on the s_axis channel is one bus tick, optionally carrying
// the frame at the front of the receive queue (tuser[0] marks it present). The
// block answers with zero or more commands on m_axis, tlast on the final one
// of the tick. Configuration is written on the cfg channel (cfg_ready is always
// high) while the block is idle.
// Ticks are handled one at a time. A tick that sends a probe or handles a reply
// passes from acceptance through the act and timer states back to idle; one that
// sends a query also passes the scan state, which skips absent nodes one per cycle.
// A sweep follows once the scan has passed the last node, and the sweep state steps
// over the node table one node per cycle while the output register is free. A probe
// is loaded into the output register from the act state once that register is free.
// Reset clears the node table, indexes, timer and mode and loads the default
// configuration; no clearing pass is needed.
// When the receiver stalls, the command waits in the output register. The sequencer
// holds only when it has a further command to load, so a tick whose last command
// is still waiting does not block the next request.
module bus_node_poll_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // frame_address[4:0], frame_data[12:5], zero[15:13]
	input  logic [2:0]  s_axis_tuser,  // frame_valid[0], frame_code[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // send_address[4:0], send_code[6:5], send_data[7]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [bnpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnpc_pkg::CFG_DATA_W-1:0] cfg_data
);

	bnpc_pkg::cmd_t    cmd;
	bnpc_pkg::status_t sts;
	logic [bnpc_pkg::ADDR_W-1:0] send_address;
	logic [bnpc_pkg::CODE_W-1:0] send_code;
	logic                        send_data;

	assign cfg_ready = 1'b1;

	bnpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (s_axis_tvalid),
		.tick_ready (s_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	bnpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_idx       (cfg_index),
		.cfg_wdata     (cfg_data),
		.frame_valid   (s_axis_tuser[0]),
		.frame_code    (s_axis_tuser[2:1]),
		.frame_address (s_axis_tdata[4:0]),
		.frame_data    (s_axis_tdata[12:5]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.send_address  (send_address),
		.send_code     (send_code),
		.send_data     (send_data),
		.last_command  (m_axis_tlast)
	);

	assign m_axis_tdata = {send_data, send_code, send_address};

endmodule

[rtl/bnpc_checker.sv]
// Port-level checker for the bus node poll controller, bound to the top level.
// Depends on bnpc_pkg and bus_node_poll_controller_top.
module bnpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);

	// hold a stalled command
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled command changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:5] != 2'd3)
		else $error("undefined command code");

	// probe and query carry no level and end their tick
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6:5] != bnpc_pkg::CODE_SET |->
			m_axis_tlast && !m_axis_tdata[7])
		else $error("probe or query malformed");

	// one tick in flight at a time
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("tick accepted while busy");

endmodule

bind bus_node_poll_controller_top bnpc_checker u_bnpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
